// ----- hw/rtl/sit_pkg.sv -----
// Shared types, codes and width helpers for the segment intersection test.
// No dependencies; every other file of the block uses it by scoped names.
`default_nettype none

package sit_pkg;

	// width of one coordinate field on the ports
	localparam int unsigned COORD_BITS = 16;
	// width of the tolerance register and of the reported fraction
	localparam int unsigned TOL_BITS = 16;
	localparam int unsigned FRAC_OUT_BITS = 16;

	// classification of a segment pair
	typedef enum logic [2:0] {
		REL_CROSSING           = 3'd0,
		REL_NO_CROSSING        = 3'd1,
		REL_PARALLEL           = 3'd2,
		REL_COLLINEAR_OVERLAP  = 3'd3,
		REL_COLLINEAR_DISJOINT = 3'd4
	} relation_t;

	// one request: two segments, signed Q12.4 end points
	typedef struct packed {
		logic signed [COORD_BITS-1:0] first_start_x;
		logic signed [COORD_BITS-1:0] first_start_y;
		logic signed [COORD_BITS-1:0] first_end_x;
		logic signed [COORD_BITS-1:0] first_end_y;
		logic signed [COORD_BITS-1:0] second_start_x;
		logic signed [COORD_BITS-1:0] second_start_y;
		logic signed [COORD_BITS-1:0] second_end_x;
		logic signed [COORD_BITS-1:0] second_end_y;
	} seg_pair_t;

	// one result
	typedef struct packed {
		logic                     hit;
		logic [FRAC_OUT_BITS-1:0] crossing_fraction;
		relation_t                relation;
	} result_t;

	// decision that travels alongside the fraction divider
	typedef struct packed {
		logic      hit;
		relation_t relation;
	} div_ctl_t;

	// coordinate width after extension of a port field
	function automatic int ext_width(input int coord_width);
		return (coord_width > 16) ? 17 : coord_width;
	endfunction

	// width of a product of two coordinate differences
	function automatic int prod_width(input int coord_width);
		return 2 * (ext_width(coord_width) + 1);
	endfunction

	// width of a sum or difference of two such products
	function automatic int sum_width(input int coord_width);
		return prod_width(coord_width) + 1;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sit_if.sv -----
// Valid/ready channel interfaces for segment requests and results.
// Depends on sit_pkg for the payload types.
`default_nettype none

interface sit_seg_if;
	logic                valid;
	logic                ready;
	sit_pkg::seg_pair_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface sit_res_if;
	logic              valid;
	logic              ready;
	sit_pkg::result_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/segment_intersection_test.sv -----
// Top level of the 2D segment intersection test.
// Depends on sit_pkg, sit_if, sit_cross, sit_classify, sit_divider, sit_skid.
//
//   channel   dir  handshake        payload
//   seg_in    in   valid / ready    sit_pkg::seg_pair_t (eight Q12.4 coordinates)
//   res_out   out  valid / ready    sit_pkg::result_t (hit, fraction, relation)
//   cfg       in   cfg_we           cfg_wdata -> zero tolerance
//
// One request enters per cycle unless stalled; results pass the cross, classify,
// divider and output stages. The divider, one quotient bit per stage, sets the depth.
// Reset clears all valid bits and sets the zero tolerance to 0. On a stall the whole
// pipeline holds; a two-entry output buffer keeps ready registered, so seg_in.ready
// drops in the cycle after res_out backs up while a new result arrives.
`default_nettype none

module segment_intersection_test #(
	parameter int COORD_WIDTH    = 16,
	parameter int FRACTION_WIDTH = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [sit_pkg::TOL_BITS-1:0] cfg_wdata,
	sit_seg_if.sink                           seg_in,
	sit_res_if.source                         res_out
);

	localparam int PW = sit_pkg::prod_width(COORD_WIDTH);
	localparam int SW = sit_pkg::sum_width(COORD_WIDTH);

	logic [sit_pkg::TOL_BITS-1:0] zero_tol_q;

	// tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_tol_q <= '0;
		end else if (cfg_we) begin
			zero_tol_q <= cfg_wdata;
		end
	end

	logic advance;

	assign seg_in.ready = advance;

	// cross and dot products
	logic                 valid_s3;
	logic signed [SW-1:0] rxs_s3, pqxr_s3, pqxs_s3, amax_s3, b0_s3, b1_s3;

	sit_cross #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_cross (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.in_valid (seg_in.valid),
		.in_data  (seg_in.data),
		.valid_s3 (valid_s3),
		.rxs_s3   (rxs_s3),
		.pqxr_s3  (pqxr_s3),
		.pqxs_s3  (pqxs_s3),
		.amax_s3  (amax_s3),
		.b0_s3    (b0_s3),
		.b1_s3    (b1_s3)
	);

	// classification
	logic              valid_s5;
	sit_pkg::div_ctl_t ctl_s5;
	logic [PW-1:0]     num_s5, den_s5;

	sit_classify #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_classify (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.zero_tol (zero_tol_q),
		.valid_s3 (valid_s3),
		.rxs_s3   (rxs_s3),
		.pqxr_s3  (pqxr_s3),
		.pqxs_s3  (pqxs_s3),
		.amax_s3  (amax_s3),
		.b0_s3    (b0_s3),
		.b1_s3    (b1_s3),
		.valid_s5 (valid_s5),
		.ctl_s5   (ctl_s5),
		.num_s5   (num_s5),
		.den_s5   (den_s5)
	);

	// crossing fraction
	logic             div_valid;
	sit_pkg::result_t div_res;

	sit_divider #(
		.COORD_WIDTH    (COORD_WIDTH),
		.FRACTION_WIDTH (FRACTION_WIDTH)
	) u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.in_valid  (valid_s5),
		.in_ctl    (ctl_s5),
		.in_num    (num_s5),
		.in_den    (den_s5),
		.out_valid (div_valid),
		.out_res   (div_res)
	);

	// output buffer
	sit_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (div_valid),
		.push_data  (div_res),
		.advance    (advance),
		.res_out    (res_out)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/sit_cross.sv -----
// Front of the pipeline: differences, products, cross and dot products.
// Three register stages; depends on sit_pkg.
`default_nettype none

module sit_cross #(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  in_valid,
	input  wire sit_pkg::seg_pair_t    in_data,
	output logic                       valid_s3,
	output logic signed [sit_pkg::sum_width(COORD_WIDTH)-1:0] rxs_s3,
	output logic signed [sit_pkg::sum_width(COORD_WIDTH)-1:0] pqxr_s3,
	output logic signed [sit_pkg::sum_width(COORD_WIDTH)-1:0] pqxs_s3,
	output logic signed [sit_pkg::sum_width(COORD_WIDTH)-1:0] amax_s3,
	output logic signed [sit_pkg::sum_width(COORD_WIDTH)-1:0] b0_s3,
	output logic signed [sit_pkg::sum_width(COORD_WIDTH)-1:0] b1_s3
);

	localparam int EW = sit_pkg::ext_width(COORD_WIDTH);
	localparam int DW = EW + 1;
	localparam int PW = sit_pkg::prod_width(COORD_WIDTH);
	localparam int SW = sit_pkg::sum_width(COORD_WIDTH);

	logic [sit_pkg::COORD_BITS-1:0] raw [8];
	logic signed [EW-1:0]           pt  [8];

	// raw fields in end point order: a, b (first), c, d (second)
	assign raw[0] = in_data.first_start_x;
	assign raw[1] = in_data.first_start_y;
	assign raw[2] = in_data.first_end_x;
	assign raw[3] = in_data.first_end_y;
	assign raw[4] = in_data.second_start_x;
	assign raw[5] = in_data.second_start_y;
	assign raw[6] = in_data.second_end_x;
	assign raw[7] = in_data.second_end_y;

	// port fields: zero-extended when COORD_WIDTH exceeds 16, else cut to the low COORD_WIDTH bits
	for (genvar i = 0; i < 8; i++) begin : g_ext
		if (COORD_WIDTH > 16) begin : g_wide
			assign pt[i] = {{(EW-16){1'b0}}, raw[i]};
		end else begin : g_narrow
			assign pt[i] = raw[i][EW-1:0];
		end
	end

	logic                 v_s1, v_s2;
	logic signed [DW-1:0] rx_s1, ry_s1, sx_s1, sy_s1, pqx_s1, pqy_s1, dax_s1, day_s1;
	logic signed [PW-1:0] rx_sy_s2, ry_sx_s2, pqx_ry_s2, pqy_rx_s2, pqx_sy_s2, pqy_sx_s2;
	logic signed [PW-1:0] rx_rx_s2, ry_ry_s2, pqx_rx_s2, pqy_ry_s2, dax_rx_s2, day_ry_s2;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			v_s1     <= in_valid;
			v_s2     <= v_s1;
			valid_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: direction vectors r, s and offsets c - a, d - a
			rx_s1  <= DW'(pt[2]) - DW'(pt[0]);
			ry_s1  <= DW'(pt[3]) - DW'(pt[1]);
			sx_s1  <= DW'(pt[6]) - DW'(pt[4]);
			sy_s1  <= DW'(pt[7]) - DW'(pt[5]);
			pqx_s1 <= DW'(pt[4]) - DW'(pt[0]);
			pqy_s1 <= DW'(pt[5]) - DW'(pt[1]);
			dax_s1 <= DW'(pt[6]) - DW'(pt[0]);
			day_s1 <= DW'(pt[7]) - DW'(pt[1]);

			// stage 2: partial products
			rx_sy_s2  <= PW'(rx_s1) * PW'(sy_s1);
			ry_sx_s2  <= PW'(ry_s1) * PW'(sx_s1);
			pqx_ry_s2 <= PW'(pqx_s1) * PW'(ry_s1);
			pqy_rx_s2 <= PW'(pqy_s1) * PW'(rx_s1);
			pqx_sy_s2 <= PW'(pqx_s1) * PW'(sy_s1);
			pqy_sx_s2 <= PW'(pqy_s1) * PW'(sx_s1);
			rx_rx_s2  <= PW'(rx_s1) * PW'(rx_s1);
			ry_ry_s2  <= PW'(ry_s1) * PW'(ry_s1);
			pqx_rx_s2 <= PW'(pqx_s1) * PW'(rx_s1);
			pqy_ry_s2 <= PW'(pqy_s1) * PW'(ry_s1);
			dax_rx_s2 <= PW'(dax_s1) * PW'(rx_s1);
			day_ry_s2 <= PW'(day_s1) * PW'(ry_s1);

			// stage 3: cross and dot products
			rxs_s3  <= SW'(rx_sy_s2) - SW'(ry_sx_s2);
			pqxr_s3 <= SW'(pqx_ry_s2) - SW'(pqy_rx_s2);
			pqxs_s3 <= SW'(pqx_sy_s2) - SW'(pqy_sx_s2);
			amax_s3 <= SW'(rx_rx_s2) + SW'(ry_ry_s2);
			b0_s3   <= SW'(pqx_rx_s2) + SW'(pqy_ry_s2);
			b1_s3   <= SW'(dax_rx_s2) + SW'(day_ry_s2);
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/sit_classify.sv -----
// Classification stages: zero tests, sign normalization, range checks.
// Two register stages; depends on sit_pkg.
`default_nettype none

module sit_classify #(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic [sit_pkg::TOL_BITS-1:0] zero_tol,
	input  wire logic                  valid_s3,
	input  wire logic signed [sit_pkg::sum_width(COORD_WIDTH)-1:0] rxs_s3,
	input  wire logic signed [sit_pkg::sum_width(COORD_WIDTH)-1:0] pqxr_s3,
	input  wire logic signed [sit_pkg::sum_width(COORD_WIDTH)-1:0] pqxs_s3,
	input  wire logic signed [sit_pkg::sum_width(COORD_WIDTH)-1:0] amax_s3,
	input  wire logic signed [sit_pkg::sum_width(COORD_WIDTH)-1:0] b0_s3,
	input  wire logic signed [sit_pkg::sum_width(COORD_WIDTH)-1:0] b1_s3,
	output logic                       valid_s5,
	output sit_pkg::div_ctl_t          ctl_s5,
	output logic [sit_pkg::prod_width(COORD_WIDTH)-1:0] num_s5,
	output logic [sit_pkg::prod_width(COORD_WIDTH)-1:0] den_s5
);

	localparam int PW = sit_pkg::prod_width(COORD_WIDTH);
	localparam int SW = sit_pkg::sum_width(COORD_WIDTH);

	logic [SW-1:0] rxs_mag, pqxr_mag, tol_ext;
	logic          rxs_neg;

	// magnitudes for the tolerance test
	assign rxs_neg  = rxs_s3[SW-1];
	assign rxs_mag  = rxs_neg ? SW'(-rxs_s3) : SW'(rxs_s3);
	assign pqxr_mag = pqxr_s3[SW-1] ? SW'(-pqxr_s3) : SW'(pqxr_s3);
	assign tol_ext  = SW'(zero_tol);

	logic                 v_s4, rxs_zero_s4, pqxr_zero_s4, overlap_s4;
	logic signed [SW-1:0] den_s4, tn_s4, un_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4     <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			v_s4     <= valid_s3;
			valid_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 4: zero tests, collinear overlap, positive denominator
			rxs_zero_s4  <= (rxs_mag <= tol_ext);
			pqxr_zero_s4 <= (pqxr_mag <= tol_ext);
			overlap_s4   <= ((b0_s3 <= amax_s3) || (b1_s3 <= amax_s3))
				&& (!b0_s3[SW-1] || !b1_s3[SW-1]);
			den_s4 <= rxs_neg ? -rxs_s3 : rxs_s3;
			tn_s4  <= rxs_neg ? -pqxs_s3 : pqxs_s3;
			un_s4  <= rxs_neg ? -pqxr_s3 : pqxr_s3;

			// stage 5: relation and divider operands
			num_s5 <= tn_s4[PW-1:0];
			den_s5 <= den_s4[PW-1:0];
			priority if (rxs_zero_s4 && pqxr_zero_s4 && overlap_s4) begin
				ctl_s5 <= '{hit: 1'b1, relation: sit_pkg::REL_COLLINEAR_OVERLAP};
			end else if (rxs_zero_s4 && pqxr_zero_s4) begin
				ctl_s5 <= '{hit: 1'b0, relation: sit_pkg::REL_COLLINEAR_DISJOINT};
			end else if (rxs_zero_s4) begin
				ctl_s5 <= '{hit: 1'b0, relation: sit_pkg::REL_PARALLEL};
			end else if (tn_s4 > 0 && tn_s4 < den_s4 && un_s4 > 0 && un_s4 < den_s4) begin
				ctl_s5 <= '{hit: 1'b1, relation: sit_pkg::REL_CROSSING};
			end else begin
				ctl_s5 <= '{hit: 1'b0, relation: sit_pkg::REL_NO_CROSSING};
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/sit_divider.sv -----
// Pipelined restoring divider for the crossing fraction, one bit per stage.
// FRACTION_WIDTH register stages; depends on sit_pkg.
`default_nettype none

module sit_divider #(
	parameter int COORD_WIDTH    = 16,
	parameter int FRACTION_WIDTH = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  in_valid,
	input  wire sit_pkg::div_ctl_t     in_ctl,
	input  wire logic [sit_pkg::prod_width(COORD_WIDTH)-1:0] in_num,
	input  wire logic [sit_pkg::prod_width(COORD_WIDTH)-1:0] in_den,
	output logic                       out_valid,
	output sit_pkg::result_t           out_res
);

	localparam int PW = sit_pkg::prod_width(COORD_WIDTH);
	localparam int FW = FRACTION_WIDTH;

	// one register set per quotient bit
	logic [FW-1:0]           v_sd;
	logic [PW-1:0]           rem_sd [FW];
	logic [PW-1:0]           den_sd [FW];
	logic [FW-1:0]           quo_sd [FW];
	sit_pkg::div_ctl_t       ctl_sd [FW];

	logic [PW-1:0] rem_in_c  [FW];
	logic [PW-1:0] den_in_c  [FW];
	logic [FW-1:0] quo_in_c  [FW];
	logic [PW:0]   shift_c   [FW];
	logic [PW:0]   diff_c    [FW];
	logic [FW-1:0] ge_c;

	// one compare and subtract per stage
	always_comb begin
		for (int k = 0; k < FW; k++) begin
			if (k == 0) begin
				rem_in_c[k] = in_num;
				den_in_c[k] = in_den;
				quo_in_c[k] = '0;
			end else begin
				rem_in_c[k] = rem_sd[k-1];
				den_in_c[k] = den_sd[k-1];
				quo_in_c[k] = quo_sd[k-1];
			end
			shift_c[k] = {rem_in_c[k], 1'b0};
			diff_c[k]  = shift_c[k] - {1'b0, den_in_c[k]};
			ge_c[k]    = (shift_c[k] >= {1'b0, den_in_c[k]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sd <= '0;
		end else if (en) begin
			v_sd <= {v_sd[FW-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < FW; k++) begin
				rem_sd[k] <= ge_c[k] ? diff_c[k][PW-1:0] : shift_c[k][PW-1:0];
				den_sd[k] <= den_in_c[k];
				quo_sd[k] <= {quo_in_c[k][FW-2:0], ge_c[k]};
				ctl_sd[k] <= (k == 0) ? in_ctl : ctl_sd[(k == 0) ? 0 : k-1];
			end
		end
	end

	// low bits of the quotient as the reported fraction
	logic [sit_pkg::FRAC_OUT_BITS-1:0] frac;

	if (FW >= sit_pkg::FRAC_OUT_BITS) begin : g_frac_trunc
		assign frac = quo_sd[FW-1][sit_pkg::FRAC_OUT_BITS-1:0];
	end else begin : g_frac_ext
		assign frac = {{(sit_pkg::FRAC_OUT_BITS-FW){1'b0}}, quo_sd[FW-1]};
	end

	assign out_valid                 = v_sd[FW-1];
	assign out_res.hit               = ctl_sd[FW-1].hit;
	assign out_res.relation          = ctl_sd[FW-1].relation;
	assign out_res.crossing_fraction =
		(ctl_sd[FW-1].relation == sit_pkg::REL_CROSSING) ? frac : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/sit_skid.sv -----
// Output skid buffer: registered result plus one spare entry.
// Drives the pipeline advance from a register; depends on sit_pkg, sit_if.
`default_nettype none

module sit_skid (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	input  wire sit_pkg::result_t push_data,
	output logic               advance,
	sit_res_if.source          res_out
);

	logic             main_v_q, spare_v_q;
	sit_pkg::result_t main_q, spare_q;
	logic             push, drain;

	assign advance = !spare_v_q;
	assign push    = push_valid && !spare_v_q;
	assign drain   = !main_v_q || res_out.ready;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q  <= 1'b0;
			spare_v_q <= 1'b0;
		end else if (drain) begin
			if (spare_v_q) begin
				main_v_q  <= 1'b1;
				spare_v_q <= 1'b0;
			end else begin
				main_v_q <= push;
			end
		end else if (push) begin
			spare_v_q <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (drain) begin
			main_q <= spare_v_q ? spare_q : push_data;
		end else if (push) begin
			spare_q <= push_data;
		end
	end

	assign res_out.valid = main_v_q;
	assign res_out.data  = main_q;

endmodule

`default_nettype wire

// ----- hw/rtl/sit_checker.sv -----
// Port-level checks for segment_intersection_test, attached by bind.
// Depends on sit_pkg for the relation codes.
`default_nettype none

module sit_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_ready,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic                              out_hit,
	input wire logic [sit_pkg::FRAC_OUT_BITS-1:0] out_fraction,
	input wire logic [2:0]                        out_relation
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_hit)
			&& $stable(out_fraction) && $stable(out_relation))
		else $error("result changed while stalled");

	// fraction only on a proper crossing
	a_frac_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_relation != sit_pkg::REL_CROSSING |-> out_fraction == '0)
		else $error("fraction nonzero outside a crossing");

	// hit agrees with the relation
	a_hit_rel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_hit == (out_relation == sit_pkg::REL_CROSSING
			|| out_relation == sit_pkg::REL_COLLINEAR_OVERLAP))
		else $error("hit disagrees with relation");

	// input backs off only after an output stall
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> $past(out_valid && !out_ready))
		else $error("input ready dropped without an output stall");

endmodule

bind segment_intersection_test sit_checker u_sit_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (seg_in.ready),
	.out_valid    (res_out.valid),
	.out_ready    (res_out.ready),
	.out_hit      (res_out.data.hit),
	.out_fraction (res_out.data.crossing_fraction),
	.out_relation (res_out.data.relation)
);

`default_nettype wire

// ----- dv/segment_intersection_test_tb.sv -----
// Self-checking bench for segment_intersection_test: directed pairs, then random phases.
// Depends on sit_pkg, sit_if and the segment_intersection_test top level.
// Results are compared field by field against table answers or a local model of the crossing math.
`timescale 1ns / 100ps

module segment_intersection_test_tb;

	localparam int PIPE_LATENCY   = 22;
	localparam int FRAC_SHIFT     = 16;
	localparam int ITEMS_PER_SET  = 100;
	localparam int MAX_REPORTS    = 10;
	localparam int unsigned CYCLE_LIMIT = 400000;

	// one row of the directed table
	typedef struct {
		sit_pkg::seg_pair_t pair;
		bit                 typed;
		sit_pkg::result_t   answer;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [15:0]        cfg_wdata;
	logic               seg_valid;
	sit_pkg::seg_pair_t seg_data;
	logic               sink_ready = 1'b0;
	bit                 calm = 1'b0;

	logic [15:0]      tol_setting;
	sit_pkg::result_t pending_results[$];
	stim_row_t        directed_rows[$];
	int               mismatch_count = 0;
	int unsigned      cycle_count = 0;

	sit_seg_if seg_if ();
	sit_res_if res_if ();

	assign seg_if.valid = seg_valid;
	assign seg_if.data  = seg_data;
	assign res_if.ready = sink_ready;

	segment_intersection_test u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.seg_in    (seg_if),
		.res_out   (res_if)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// watchdog
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("segment_intersection_test_tb: FAIL");
		$finish;
	end

	// result side back-pressure
	always @(posedge clk) begin
		sink_ready <= calm || ($urandom_range(99) >= 25);
	end

	// cross product magnitude counts as zero
	function automatic bit is_negligible(input longint value, input logic [15:0] tol);
		longint mag;
		mag = (value < 0) ? -value : value;
		return mag <= longint'({48'd0, tol});
	endfunction

	// classify one segment pair and form the crossing fraction
	function automatic sit_pkg::result_t predict_crossing(input sit_pkg::seg_pair_t p,
			input logic [15:0] tol);
		longint ax, ay, bx, by, cx, cy, dx, dy;
		longint rx, ry, sx, sy, qx, qy;
		longint rxs, qxr, qxs, den, tn, un;
		longint span, b0, b1, lo, hi;
		longint unsigned scaled;
		sit_pkg::result_t res;
		ax = longint'($signed(p.first_start_x));
		ay = longint'($signed(p.first_start_y));
		bx = longint'($signed(p.first_end_x));
		by = longint'($signed(p.first_end_y));
		cx = longint'($signed(p.second_start_x));
		cy = longint'($signed(p.second_start_y));
		dx = longint'($signed(p.second_end_x));
		dy = longint'($signed(p.second_end_y));
		res.hit = 1'b0;
		res.crossing_fraction = '0;
		res.relation = sit_pkg::REL_NO_CROSSING;
		rx = bx - ax;
		ry = by - ay;
		sx = dx - cx;
		sy = dy - cy;
		qx = cx - ax;
		qy = cy - ay;
		rxs = rx * sy - ry * sx;
		qxr = qx * ry - qy * rx;
		if (is_negligible(rxs, tol)) begin
			if (is_negligible(qxr, tol)) begin
				// project the second segment onto the first
				span = rx * rx + ry * ry;
				b0 = qx * rx + qy * ry;
				b1 = (dx - ax) * rx + (dy - ay) * ry;
				lo = (b0 < b1) ? b0 : b1;
				hi = (b0 < b1) ? b1 : b0;
				if (lo <= span && hi >= 0) begin
					res.hit = 1'b1;
					res.relation = sit_pkg::REL_COLLINEAR_OVERLAP;
				end else begin
					res.relation = sit_pkg::REL_COLLINEAR_DISJOINT;
				end
			end else begin
				res.relation = sit_pkg::REL_PARALLEL;
			end
		end else begin
			qxs = qx * sy - qy * sx;
			den = rxs;
			tn = qxs;
			un = qxr;
			if (den < 0) begin
				den = -den;
				tn = -tn;
				un = -un;
			end
			if (tn > 0 && tn < den && un > 0 && un < den) begin
				scaled = (longint'(tn) << FRAC_SHIFT) / den;
				res.hit = 1'b1;
				res.relation = sit_pkg::REL_CROSSING;
				res.crossing_fraction = scaled[15:0];
			end
		end
		return res;
	endfunction

	function automatic sit_pkg::seg_pair_t make_pair(input int x0, input int y0,
			input int x1, input int y1, input int x2, input int y2, input int x3,
			input int y3);
		sit_pkg::seg_pair_t p;
		p.first_start_x  = 16'(x0);
		p.first_start_y  = 16'(y0);
		p.first_end_x    = 16'(x1);
		p.first_end_y    = 16'(y1);
		p.second_start_x = 16'(x2);
		p.second_start_y = 16'(y2);
		p.second_end_x   = 16'(x3);
		p.second_end_y   = 16'(y3);
		return p;
	endfunction

	function automatic sit_pkg::result_t make_result(input logic hit, input logic [15:0] frac,
			input sit_pkg::relation_t rel);
		sit_pkg::result_t r;
		r.hit = hit;
		r.crossing_fraction = frac;
		r.relation = rel;
		return r;
	endfunction

	task automatic add_row(input sit_pkg::seg_pair_t p, input bit typed,
			input sit_pkg::result_t answer);
		stim_row_t row;
		row.pair = p;
		row.typed = typed;
		row.answer = answer;
		directed_rows.push_back(row);
	endtask

	// random pair: wide noise, small boxes that cross often, or lines built collinear
	function automatic sit_pkg::seg_pair_t random_pair();
		int kind, bx, by, dx, dy, m, jx, jy;
		int k0, k1, k2, k3;
		sit_pkg::seg_pair_t p;
		kind = $urandom_range(99);
		if (kind < 35) begin
			p = sit_pkg::seg_pair_t'({$urandom(), $urandom(), $urandom(), $urandom()});
		end else if (kind < 75) begin
			p = make_pair($urandom_range(511) - 256, $urandom_range(511) - 256,
				$urandom_range(511) - 256, $urandom_range(511) - 256,
				$urandom_range(511) - 256, $urandom_range(511) - 256,
				$urandom_range(511) - 256, $urandom_range(511) - 256);
		end else begin
			bx = $urandom_range(2000) - 1000;
			by = $urandom_range(2000) - 1000;
			dx = $urandom_range(128) - 64;
			dy = $urandom_range(128) - 64;
			k0 = $urandom_range(16) - 8;
			k1 = $urandom_range(16) - 8;
			k2 = $urandom_range(16) - 8;
			k3 = $urandom_range(16) - 8;
			// offset of the second line: none, perpendicular, or a slight nudge
			m = ($urandom_range(1) == 0) ? 0 : $urandom_range(6) - 3;
			jx = ($urandom_range(3) == 0) ? $urandom_range(2) - 1 : 0;
			jy = ($urandom_range(3) == 0) ? $urandom_range(2) - 1 : 0;
			p = make_pair(bx + k0 * dx, by + k0 * dy, bx + k1 * dx, by + k1 * dy,
				bx + k2 * dx - m * dy, by + k2 * dy + m * dx,
				bx + k3 * dx - m * dy + jx, by + k3 * dy + m * dx + jy);
		end
		return p;
	endfunction

	// present one request, with random idle cycles ahead of it
	task automatic send_request(input sit_pkg::seg_pair_t p, input bit typed,
			input sit_pkg::result_t answer);
		while (!calm && $urandom_range(99) < 25) begin
			seg_valid <= 1'b0;
			@(posedge clk);
		end
		seg_valid <= 1'b1;
		seg_data  <= p;
		do @(posedge clk); while (!seg_if.ready);
		if (typed)
			pending_results.push_back(answer);
		else
			pending_results.push_back(predict_crossing(p, tol_setting));
	endtask

	// hold off requests until the pipeline is empty
	task automatic wait_for_drain();
		seg_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 8) @(posedge clk);
	endtask

	task automatic write_tolerance(input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		tol_setting = value;
	endtask

	// result checker
	always @(posedge clk) begin
		sit_pkg::result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result: hit %0b frac %h rel %0d",
						res_if.data.hit, res_if.data.crossing_fraction,
						res_if.data.relation);
			end else begin
				want = pending_results.pop_front();
				if (res_if.data.hit !== want.hit
						|| res_if.data.crossing_fraction !== want.crossing_fraction
						|| res_if.data.relation !== want.relation) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("mismatch: exp %0b %h %0d, got %0b %h %0d",
							want.hit, want.crossing_fraction, want.relation,
							res_if.data.hit, res_if.data.crossing_fraction,
							res_if.data.relation);
				end
			end
		end
	end

	// stimulus
	initial begin
		logic [15:0] tol_plan [6];
		sit_pkg::result_t none;
		arst_n    <= 1'b0;
		seg_valid <= 1'b0;
		seg_data  <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		tol_setting = '0;
		none = make_result(1'b0, 16'd0, sit_pkg::REL_NO_CROSSING);

		// directed table, coordinates in Q12.4 (16 is one unit)
		add_row(make_pair(0, 0, 0, 0, 0, 0, 0, 0), 1,
			make_result(1'b1, 16'd0, sit_pkg::REL_COLLINEAR_OVERLAP));
		add_row(make_pair(0, 0, 32, 32, 0, 32, 32, 0), 1,
			make_result(1'b1, 16'h8000, sit_pkg::REL_CROSSING));
		// crossing exactly at the end of the first segment
		add_row(make_pair(0, 0, 32, 0, 32, -16, 32, 16), 1,
			make_result(1'b0, 16'd0, sit_pkg::REL_NO_CROSSING));
		// second segment starts on the first one
		add_row(make_pair(0, 0, 32, 0, 16, 0, 16, 32), 1,
			make_result(1'b0, 16'd0, sit_pkg::REL_NO_CROSSING));
		add_row(make_pair(0, 0, 32, 0, 0, 16, 32, 16), 1,
			make_result(1'b0, 16'd0, sit_pkg::REL_PARALLEL));
		// collinear, touching at one end point only
		add_row(make_pair(0, 0, 16, 0, 16, 0, 32, 0), 1,
			make_result(1'b1, 16'd0, sit_pkg::REL_COLLINEAR_OVERLAP));
		add_row(make_pair(0, 0, 16, 0, 32, 0, 48, 0), 1,
			make_result(1'b0, 16'd0, sit_pkg::REL_COLLINEAR_DISJOINT));
		add_row(make_pair(0, 0, 16, 0, 24, 0, 8, 0), 0, none);
		add_row(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767), 1,
			make_result(1'b1, 16'd0, sit_pkg::REL_COLLINEAR_OVERLAP));
		add_row(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768),
			1, make_result(1'b1, 16'd0, sit_pkg::REL_COLLINEAR_OVERLAP));
		add_row(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768), 0, none);
		add_row(make_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767), 0, none);
		add_row(make_pair(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768), 0, none);
		// zero-length first segment, then zero-length second segment
		add_row(make_pair(0, 0, 0, 0, 16, 16, 32, 0), 0, none);
		add_row(make_pair(0, 0, 32, 32, 48, 48, 48, 48), 0, none);
		add_row(make_pair(0, 0, 16, 0, 32, -16, 32, 16), 0, none);
		add_row(make_pair(0, 0, 48, 16, 10, -20, 5, 30), 0, none);
		add_row(make_pair(-5, 3, 7, -1, 1, 9, 2, -11), 0, none);
		add_row(make_pair(0, 0, 32767, 1, 1, -32768, 2, 32767), 0, none);
		add_row(make_pair(100, 0, -100, 0, 0, 1, 0, -32768), 0, none);

		tol_plan = '{16'hFFFF, 16'd0, 16'd1, 16'(($urandom_range(4095))), 16'h00FF, 16'h8000};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].pair, directed_rows[i].typed,
				directed_rows[i].answer);
		wait_for_drain();

		// random phases, one tolerance each; phase 2 runs with no idling on either side
		for (int phase = 0; phase < 6; phase++) begin
			write_tolerance(tol_plan[phase]);
			calm = (phase == 2);
			for (int n = 0; n < ITEMS_PER_SET; n++) begin
				send_request(random_pair(), 1'b0, none);
				if (phase == 3 && n == ITEMS_PER_SET / 2)
					wait_for_drain();
			end
			wait_for_drain();
		end
		calm = 1'b0;

		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("segment_intersection_test_tb: PASS");
		end else begin
			$display("segment_intersection_test_tb: FAIL");
		end
		$finish;
	end

endmodule
